[rtl/core/pcbb_pkg.sv]
// ----------------------------------------------------------------------------
// pcbb_pkg
// Shared codes, field widths and stage bundles for the path command bounding
// box block.
// ----------------------------------------------------------------------------
package pcbb_pkg;

    localparam int ARG_W     = 32;
    localparam int OUT_W     = 32;
    localparam int ARG_COUNT = 7;
    localparam int LANES     = 3;

    // command kinds
    localparam logic [3:0] KIND_MOVE   = 4'd0;
    localparam logic [3:0] KIND_LINE   = 4'd1;
    localparam logic [3:0] KIND_SQUAD  = 4'd2;
    localparam logic [3:0] KIND_HORIZ  = 4'd3;
    localparam logic [3:0] KIND_VERT   = 4'd4;
    localparam logic [3:0] KIND_CUBIC  = 4'd5;
    localparam logic [3:0] KIND_SCUBIC = 4'd6;
    localparam logic [3:0] KIND_QUAD   = 4'd7;
    localparam logic [3:0] KIND_CLOSE  = 4'd8;
    localparam logic [3:0] KIND_ARC    = 4'd9;

    // argument slots
    localparam logic [2:0] ARG_A = 3'd0;
    localparam logic [2:0] ARG_B = 3'd1;
    localparam logic [2:0] ARG_C = 3'd2;
    localparam logic [2:0] ARG_D = 3'd3;
    localparam logic [2:0] ARG_E = 3'd4;
    localparam logic [2:0] ARG_F = 3'd5;
    localparam logic [2:0] ARG_G = 3'd6;

    // point lanes
    localparam logic [1:0] LANE_END = 2'd0;
    localparam logic [1:0] LANE_C1  = 2'd1;
    localparam logic [1:0] LANE_C2  = 2'd2;

    localparam logic signed [OUT_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [OUT_W-1:0] S32_MIN = 32'sh8000_0000;

    // control that travels with the resolved points
    typedef struct packed {
        logic             clr;
        logic [LANES-1:0] pt_valid;
    } pcbb_ctl_t;

    // pipeline enables from the top level to the merge stage
    typedef struct packed {
        logic load;
        logic upd;
    } pcbb_step_t;

    // formatted result
    typedef struct packed {
        logic signed [OUT_W-1:0] left;
        logic signed [OUT_W-1:0] top;
        logic [OUT_W-1:0]        width;
        logic [OUT_W-1:0]        height;
        logic                    has_points;
    } pcbb_box_t;

endpackage

[rtl/core/pcbb_if.sv]
// ----------------------------------------------------------------------------
// pcbb_if
// Valid/ready channels for path commands in and bounding boxes out.
// ----------------------------------------------------------------------------
interface pcbb_cmd_if;
    logic               valid;
    logic               ready;
    logic               path_start;
    logic [3:0]         kind;
    logic               relative;
    logic signed [31:0] arg_a;
    logic signed [31:0] arg_b;
    logic signed [31:0] arg_c;
    logic signed [31:0] arg_d;
    logic signed [31:0] arg_e;
    logic signed [31:0] arg_f;
    logic signed [31:0] arg_g;

    modport source (
        output valid, path_start, kind, relative,
        output arg_a, arg_b, arg_c, arg_d, arg_e, arg_f, arg_g,
        input  ready
    );
    modport sink (
        input  valid, path_start, kind, relative,
        input  arg_a, arg_b, arg_c, arg_d, arg_e, arg_f, arg_g,
        output ready
    );
endinterface

interface pcbb_box_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] box_left;
    logic signed [31:0] box_top;
    logic [31:0]        box_width;
    logic [31:0]        box_height;
    logic               has_points;

    modport source (
        output valid, box_left, box_top, box_width, box_height, has_points,
        input  ready
    );
    modport sink (
        input  valid, box_left, box_top, box_width, box_height, has_points,
        output ready
    );
endinterface

[rtl/core/pcbb_lane.sv]
// ----------------------------------------------------------------------------
// pcbb_lane
// Resolves one argument pair to an absolute point: optional pen offset,
// then saturation to the coordinate range. Either axis may keep the pen.
// ----------------------------------------------------------------------------
module pcbb_lane
    import pcbb_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic signed [ARG_W-1:0]      arg_x,
    input  logic signed [ARG_W-1:0]      arg_y,
    input  logic                         relative,
    input  logic                         hold_x,
    input  logic                         hold_y,
    input  logic signed [COORD_BITS-1:0] base_x,
    input  logic signed [COORD_BITS-1:0] base_y,
    output logic signed [COORD_BITS-1:0] pt_x,
    output logic signed [COORD_BITS-1:0] pt_y
);

    localparam int EXT_W = ((COORD_BITS > ARG_W) ? COORD_BITS : ARG_W) + 1;
    localparam int SUM_W = EXT_W + 1;
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

    function automatic logic signed [COORD_BITS-1:0] resolve(
        input logic signed [ARG_W-1:0]      arg,
        input logic                         rel,
        input logic signed [COORD_BITS-1:0] base
    );
        logic signed [SUM_W-1:0] sum;
        sum = SUM_W'(arg);
        if (rel)
        begin
            sum = sum + SUM_W'(base);
        end
        if (sum > SUM_W'(C_MAX))
        begin
            return C_MAX;
        end
        else if (sum < SUM_W'(C_MIN))
        begin
            return C_MIN;
        end
        return sum[COORD_BITS-1:0];
    endfunction

    assign pt_x = hold_x ? base_x : resolve(arg_x, relative, base_x);
    assign pt_y = hold_y ? base_y : resolve(arg_y, relative, base_y);

endmodule

[rtl/core/pcbb_front.sv]
// ----------------------------------------------------------------------------
// pcbb_front
// Decodes a command, steers its arguments onto the point lanes, keeps the pen
// and subpath start, and registers the resolved points.
// ----------------------------------------------------------------------------
module pcbb_front
    import pcbb_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         accept,
    input  logic                         path_start,
    input  logic [3:0]                   kind,
    input  logic                         relative,
    input  logic signed [ARG_W-1:0]      arg [ARG_COUNT],
    output logic signed [COORD_BITS-1:0] pt_x [LANES],
    output logic signed [COORD_BITS-1:0] pt_y [LANES],
    output pcbb_ctl_t                    ctl
);

    logic signed [COORD_BITS-1:0] pen_x_reg, pen_y_reg, sub_x_reg, sub_y_reg;
    logic signed [COORD_BITS-1:0] pen_x_next, pen_y_next, sub_x_next, sub_y_next;
    logic signed [COORD_BITS-1:0] base_x, base_y, sub_base_x, sub_base_y;

    logic signed [ARG_W-1:0]      sel_x [LANES];
    logic signed [ARG_W-1:0]      sel_y [LANES];
    logic [LANES-1:0]             hold_x, hold_y, mask;
    logic                         is_move, is_close;

    logic signed [COORD_BITS-1:0] lane_x [LANES];
    logic signed [COORD_BITS-1:0] lane_y [LANES];

    logic signed [COORD_BITS-1:0] pt_x_reg [LANES];
    logic signed [COORD_BITS-1:0] pt_y_reg [LANES];
    pcbb_ctl_t                    ctl_reg;

    // a path start sees a cleared pen and subpath start
    assign base_x     = path_start ? '0 : pen_x_reg;
    assign base_y     = path_start ? '0 : pen_y_reg;
    assign sub_base_x = path_start ? '0 : sub_x_reg;
    assign sub_base_y = path_start ? '0 : sub_y_reg;

    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            sel_x[i] = '0;
            sel_y[i] = '0;
        end
        hold_x   = '0;
        hold_y   = '0;
        mask     = '0;
        is_move  = 1'b0;
        is_close = 1'b0;
        case (kind)
            KIND_MOVE, KIND_LINE, KIND_SQUAD:
            begin
                sel_x[LANE_END] = arg[ARG_A];
                sel_y[LANE_END] = arg[ARG_B];
                mask[LANE_END]  = 1'b1;
                is_move         = (kind == KIND_MOVE);
            end
            KIND_HORIZ:
            begin
                sel_x[LANE_END]  = arg[ARG_A];
                hold_y[LANE_END] = 1'b1;
                mask[LANE_END]   = 1'b1;
            end
            KIND_VERT:
            begin
                sel_y[LANE_END]  = arg[ARG_A];
                hold_x[LANE_END] = 1'b1;
                mask[LANE_END]   = 1'b1;
            end
            KIND_CUBIC:
            begin
                sel_x[LANE_END] = arg[ARG_E];
                sel_y[LANE_END] = arg[ARG_F];
                sel_x[LANE_C1]  = arg[ARG_A];
                sel_y[LANE_C1]  = arg[ARG_B];
                sel_x[LANE_C2]  = arg[ARG_C];
                sel_y[LANE_C2]  = arg[ARG_D];
                mask            = '1;
            end
            KIND_SCUBIC, KIND_QUAD:
            begin
                sel_x[LANE_END] = arg[ARG_C];
                sel_y[LANE_END] = arg[ARG_D];
                sel_x[LANE_C1]  = arg[ARG_A];
                sel_y[LANE_C1]  = arg[ARG_B];
                mask[LANE_END]  = 1'b1;
                mask[LANE_C1]   = 1'b1;
            end
            KIND_CLOSE:
            begin
                is_close = 1'b1;
            end
            KIND_ARC:
            begin
                sel_x[LANE_END] = arg[ARG_F];
                sel_y[LANE_END] = arg[ARG_G];
                mask[LANE_END]  = 1'b1;
            end
            default:
            begin
                mask = '0;
            end
        endcase
    end

    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        pcbb_lane #(
            .COORD_BITS (COORD_BITS)
        ) u_lane (
            .arg_x    (sel_x[g]),
            .arg_y    (sel_y[g]),
            .relative (relative),
            .hold_x   (hold_x[g]),
            .hold_y   (hold_y[g]),
            .base_x   (base_x),
            .base_y   (base_y),
            .pt_x     (lane_x[g]),
            .pt_y     (lane_y[g])
        );
    end

    always_comb
    begin
        if (mask[LANE_END])
        begin
            pen_x_next = lane_x[LANE_END];
            pen_y_next = lane_y[LANE_END];
        end
        else if (is_close)
        begin
            pen_x_next = sub_base_x;
            pen_y_next = sub_base_y;
        end
        else
        begin
            pen_x_next = base_x;
            pen_y_next = base_y;
        end
        sub_x_next = is_move ? lane_x[LANE_END] : sub_base_x;
        sub_y_next = is_move ? lane_y[LANE_END] : sub_base_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_x_reg <= '0;
            pen_y_reg <= '0;
            sub_x_reg <= '0;
            sub_y_reg <= '0;
        end
        else if (accept)
        begin
            pen_x_reg <= pen_x_next;
            pen_y_reg <= pen_y_next;
            sub_x_reg <= sub_x_next;
            sub_y_reg <= sub_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                pt_x_reg[i] <= lane_x[i];
                pt_y_reg[i] <= lane_y[i];
            end
            ctl_reg.clr      <= path_start;
            ctl_reg.pt_valid <= mask;
        end
    end

    assign pt_x = pt_x_reg;
    assign pt_y = pt_y_reg;
    assign ctl  = ctl_reg;

endmodule

[rtl/core/pcbb_merge.sv]
// ----------------------------------------------------------------------------
// pcbb_merge
// Reduces the lane points of one command to its own extent, folds that into
// the running box and formats the box for the output.
// ----------------------------------------------------------------------------
module pcbb_merge
    import pcbb_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  pcbb_step_t                   step,
    input  logic signed [COORD_BITS-1:0] pt_x [LANES],
    input  logic signed [COORD_BITS-1:0] pt_y [LANES],
    input  pcbb_ctl_t                    ctl,
    output pcbb_box_t                    fmt
);

    localparam int EXT_W  = ((COORD_BITS > OUT_W) ? COORD_BITS : OUT_W) + 1;
    localparam int SPAN_W = EXT_W + 1;
    localparam logic signed [COORD_BITS-1:0] C_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
    localparam logic signed [COORD_BITS-1:0] C_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};
    localparam logic signed [SPAN_W-1:0]     U32_MAX = SPAN_W'({1'b0, {OUT_W{1'b1}}});

    logic signed [COORD_BITS-1:0] red_lo_x, red_hi_x, red_lo_y, red_hi_y;
    logic                         red_any;

    logic signed [COORD_BITS-1:0] lo_x_reg, hi_x_reg, lo_y_reg, hi_y_reg;
    logic                         any_reg, clr_reg;

    logic signed [COORD_BITS-1:0] low_x_reg, high_x_reg, low_y_reg, high_y_reg;
    logic                         seen_reg;
    logic signed [COORD_BITS-1:0] base_lo_x, base_hi_x, base_lo_y, base_hi_y;
    logic signed [COORD_BITS-1:0] low_x_next, high_x_next, low_y_next, high_y_next;
    logic                         seen_next;

    function automatic logic signed [OUT_W-1:0] to_s32(
        input logic signed [COORD_BITS-1:0] v
    );
        logic signed [EXT_W-1:0] e;
        e = EXT_W'(v);
        if (e > EXT_W'(S32_MAX))
        begin
            return S32_MAX;
        end
        else if (e < EXT_W'(S32_MIN))
        begin
            return S32_MIN;
        end
        return e[OUT_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] span(
        input logic signed [COORD_BITS-1:0] hi,
        input logic signed [COORD_BITS-1:0] lo
    );
        logic signed [SPAN_W-1:0] d;
        d = SPAN_W'(hi) - SPAN_W'(lo);
        if (d < 0)
        begin
            return '0;
        end
        else if (d > U32_MAX)
        begin
            return '1;
        end
        return d[OUT_W-1:0];
    endfunction

    // extent of this command's points; empty leaves the reset values
    always_comb
    begin
        red_lo_x = C_MAX;
        red_hi_x = C_MIN;
        red_lo_y = C_MAX;
        red_hi_y = C_MIN;
        red_any  = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            if (ctl.pt_valid[i])
            begin
                if (pt_x[i] < red_lo_x) red_lo_x = pt_x[i];
                if (pt_x[i] > red_hi_x) red_hi_x = pt_x[i];
                if (pt_y[i] < red_lo_y) red_lo_y = pt_y[i];
                if (pt_y[i] > red_hi_y) red_hi_y = pt_y[i];
                red_any = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.load)
        begin
            lo_x_reg <= red_lo_x;
            hi_x_reg <= red_hi_x;
            lo_y_reg <= red_lo_y;
            hi_y_reg <= red_hi_y;
            any_reg  <= red_any;
            clr_reg  <= ctl.clr;
        end
    end

    always_comb
    begin
        base_lo_x   = clr_reg ? C_MAX : low_x_reg;
        base_hi_x   = clr_reg ? C_MIN : high_x_reg;
        base_lo_y   = clr_reg ? C_MAX : low_y_reg;
        base_hi_y   = clr_reg ? C_MIN : high_y_reg;
        low_x_next  = (lo_x_reg < base_lo_x) ? lo_x_reg : base_lo_x;
        high_x_next = (hi_x_reg > base_hi_x) ? hi_x_reg : base_hi_x;
        low_y_next  = (lo_y_reg < base_lo_y) ? lo_y_reg : base_lo_y;
        high_y_next = (hi_y_reg > base_hi_y) ? hi_y_reg : base_hi_y;
        seen_next   = (seen_reg && !clr_reg) || any_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_x_reg  <= C_MAX;
            high_x_reg <= C_MIN;
            low_y_reg  <= C_MAX;
            high_y_reg <= C_MIN;
            seen_reg   <= 1'b0;
        end
        else if (step.upd)
        begin
            low_x_reg  <= low_x_next;
            high_x_reg <= high_x_next;
            low_y_reg  <= low_y_next;
            high_y_reg <= high_y_next;
            seen_reg   <= seen_next;
        end
    end

    always_comb
    begin
        if (seen_reg)
        begin
            fmt.left       = to_s32(low_x_reg);
            fmt.top        = to_s32(low_y_reg);
            fmt.width      = span(high_x_reg, low_x_reg);
            fmt.height     = span(high_y_reg, low_y_reg);
            fmt.has_points = 1'b1;
        end
        else
        begin
            fmt = '0;
        end
    end

endmodule

[rtl/core/path_command_bounding_box.sv]
// ----------------------------------------------------------------------------
// path_command_bounding_box
// Stages: front point, merge extent, running box and output registers.
// Throughput: one command per cycle unless the output stalls; the pen register
// loop resolves each command's points combinationally in three parallel lanes.
// Reset: pen, subpath start and box clear; all pipeline stages empty.
// ----------------------------------------------------------------------------
module path_command_bounding_box
    import pcbb_pkg::*;
#(
    parameter int COORD_BITS = 32
)
(
    input  logic       clk,
    input  logic       rst_n,
    pcbb_cmd_if.sink   cmd,
    pcbb_box_if.source box
);

    logic                         adv, accept;
    logic                         s1_valid_reg, s2_valid_reg, s3_valid_reg, out_valid_reg;
    logic signed [ARG_W-1:0]      arg [ARG_COUNT];
    logic signed [COORD_BITS-1:0] pt_x [LANES];
    logic signed [COORD_BITS-1:0] pt_y [LANES];
    pcbb_ctl_t                    ctl;
    pcbb_step_t                   step;
    pcbb_box_t                    fmt, out_reg;

    // whole pipeline advances while the output register can take a result
    assign adv       = !out_valid_reg || box.ready;
    assign accept    = cmd.valid && adv;
    assign cmd.ready = adv;

    assign arg[ARG_A] = cmd.arg_a;
    assign arg[ARG_B] = cmd.arg_b;
    assign arg[ARG_C] = cmd.arg_c;
    assign arg[ARG_D] = cmd.arg_d;
    assign arg[ARG_E] = cmd.arg_e;
    assign arg[ARG_F] = cmd.arg_f;
    assign arg[ARG_G] = cmd.arg_g;

    pcbb_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .path_start (cmd.path_start),
        .kind       (cmd.kind),
        .relative   (cmd.relative),
        .arg        (arg),
        .pt_x       (pt_x),
        .pt_y       (pt_y),
        .ctl        (ctl)
    );

    assign step.load = adv;
    assign step.upd  = adv && s2_valid_reg;

    pcbb_merge #(
        .COORD_BITS (COORD_BITS)
    ) u_merge (
        .clk   (clk),
        .rst_n (rst_n),
        .step  (step),
        .pt_x  (pt_x),
        .pt_y  (pt_y),
        .ctl   (ctl),
        .fmt   (fmt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg  <= accept;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    // capture the box as it stands after this command's update
    always_ff @(posedge clk)
    begin
        if (adv && s3_valid_reg)
        begin
            out_reg <= fmt;
        end
    end

    assign box.valid      = out_valid_reg;
    assign box.box_left   = out_reg.left;
    assign box.box_top    = out_reg.top;
    assign box.box_width  = out_reg.width;
    assign box.box_height = out_reg.height;
    assign box.has_points = out_reg.has_points;

endmodule

[rtl/core/pcbb_checker.sv]
// ----------------------------------------------------------------------------
// pcbb_checker
// Port-level checks on the path command bounding box channels.
// ----------------------------------------------------------------------------
module pcbb_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        cmd_ready,
    input logic        box_valid,
    input logic        box_ready,
    input logic [31:0] box_left,
    input logic [31:0] box_top,
    input logic [31:0] box_width,
    input logic [31:0] box_height,
    input logic        has_points
);

    // a stalled result holds
    a_box_hold: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !box_ready |=> box_valid && $stable(box_left) && $stable(box_top)
            && $stable(box_width) && $stable(box_height) && $stable(has_points))
        else $error("stalled box transfer changed");

    // an empty box reads as all zeros
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        box_valid && !has_points |-> box_left == 32'd0 && box_top == 32'd0
            && box_width == 32'd0 && box_height == 32'd0)
        else $error("empty box with nonzero fields");

    // commands are taken whenever the output register is free or draining
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !box_valid || box_ready |-> cmd_ready)
        else $error("command channel stalled with free output");

    // nothing leaves during reset or at the first edge after it
    a_reset_quiet: assert property (@(posedge clk)
        !rst_n |=> !box_valid)
        else $error("box valid during reset");

endmodule

bind path_command_bounding_box pcbb_checker u_pcbb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_ready  (cmd.ready),
    .box_valid  (box.valid),
    .box_ready  (box.ready),
    .box_left   (box.box_left),
    .box_top    (box.box_top),
    .box_width  (box.box_width),
    .box_height (box.box_height),
    .has_points (box.has_points)
);
